// ===== rtl/core/apjd_pkg.sv =====
// shared types and constants of the antagonistic pid joint drive
// used by apjd_smul, apjd_sdiv and antagonistic_pid_joint_drive
package apjd_pkg;

    localparam int JOINT_COUNT = 4;
    localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    localparam int SEL_W    = 2;
    localparam int ANGLE_W  = 18;
    localparam int ERR_W    = 19;
    localparam int DIFF_W   = 20;
    localparam int INTEG_W  = 18;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 17;
    localparam int OFFSET_W = 16;
    localparam int SETPT_W  = 19;
    localparam int RES_W    = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_OFFSET = 3'd4;

    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd256;
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = 16'd0;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 16'd0;
    localparam logic [LIMIT_W-1:0]  INTEG_LIMIT_RST = 17'd92160;
    localparam logic [OFFSET_W-1:0] TONE_OFFSET_RST = 16'd5120;

    localparam int RESULT_MAX = 262144;
    localparam int SMOOTH     = 12800;
    localparam int SMOOTH_DIV = 51200;

    // serial multiplier: signed multiplicand, unsigned multiplier bits
    localparam int MUL_XW    = 21;
    localparam int MUL_MW    = 16;
    localparam int MUL_STEPS = MUL_MW;
    localparam int SQ_W      = 15;

    // serial divider by the smoothing constant
    localparam int DIV_NW    = 30;
    localparam int DIV_QW    = 14;
    localparam int DIV_RW    = DIV_NW - DIV_QW;
    localparam int DIV_STEPS = DIV_QW;

    localparam int CNT_W = 4;

    typedef struct packed {
        logic load;
        logic step;
    } seq_ctl_t;

endpackage

// ===== rtl/core/antagonistic_pid_joint_drive.sv =====
// per-joint pid with antagonistic flexor/extensor split, bit-serial datapath
// the result is registered after the serial multiply, integral update, clamp and split when
// outside the smoothing band; inside it a serial square and a serial divide come first;
// one item at a time, the next is accepted once the result is registered and the block is
// idle again. reset (synchronous, aresetn low) restores register defaults and
// clears the per-joint integral and previous error. depends on apjd_pkg, apjd_smul, apjd_sdiv
module antagonistic_pid_joint_drive import apjd_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SEL_W-1:0]          s_joint_sel,
    input  logic signed [ANGLE_W-1:0] s_target_angle,
    input  logic signed [ANGLE_W-1:0] s_measured_angle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SEL_W-1:0]          m_joint_out,
    output logic [SETPT_W-1:0]        m_flexor_setpoint,
    output logic [SETPT_W-1:0]        m_extensor_setpoint,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_INTEG = 4'd2;
    localparam logic [3:0] S_RES   = 4'd3;
    localparam logic [3:0] S_SPLIT = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_DLOAD = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int PQ_W = MUL_XW + 1 + MUL_MW - 8;
    localparam logic signed [31:0] RMAX_S   = 32'(RESULT_MAX);
    localparam logic [CNT_W-1:0]   MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(DIV_STEPS - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    logic [GAIN_W-1:0]   pg_reg, ig_reg, dg_reg;
    logic [LIMIT_W-1:0]  lim_reg;
    logic [OFFSET_W-1:0] off_reg;

    logic signed [INTEG_W-1:0] integ_store_reg [JOINT_COUNT];
    logic signed [ERR_W-1:0]   prev_error_reg  [JOINT_COUNT];

    logic [SEL_W-1:0]          sel_reg;
    logic                      jvalid_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [INTEG_W-1:0] integ_old_reg, i_reg, i_next;
    logic signed [30:0]        pd_reg, pd_next;
    logic signed [RES_W-1:0]   r_reg, r_next;
    logic [SETPT_W-1:0]        fl_reg, fl_next, ex_reg, ex_next;
    logic [SEL_W-1:0]          out_sel_reg;
    logic [SETPT_W-1:0]        out_fl_reg, out_ex_reg;

    logic                      in_fire, out_load;
    logic [JIDX_W-1:0]         jidx;
    logic                      jvalid;
    logic signed [ERR_W-1:0]   e_in, prev_in;
    logic signed [INTEG_W-1:0] integ_in;
    logic signed [DIFF_W-1:0]  diff_in;

    seq_ctl_t                  mul_ctl, div_ctl;
    logic signed [MUL_XW-1:0]  x0, x1, x2;
    logic [MUL_MW-1:0]         mm0, mm1;
    logic signed [MUL_XW:0]    hi0, hi1, hi2;
    logic [MUL_MW-1:0]         lo0, lo1, lo2;
    logic [DIV_QW-1:0]         q0, q1;
    logic [MUL_XW+MUL_MW:0]    sq0, sq1;

    logic signed [PQ_W-1:0]    p_q, d_q, i_q;
    logic signed [30:0]        isum, lim_s;
    logic signed [31:0]        rsum;
    logic signed [MUL_XW-1:0]  sa_w, sb_w;
    logic signed [MUL_XW-1:0]  r_ext, off_ext;
    logic signed [MUL_XW-1:0]  fl_neg, ex_pos;
    logic                      neg_side, pos_side;

    // input capture and state read
    always_comb begin
        in_fire  = s_valid && s_ready;
        jidx     = JIDX_W'(s_joint_sel);
        jvalid   = int'(s_joint_sel) < JOINT_COUNT;
        e_in     = {s_target_angle[ANGLE_W-1], s_target_angle}
                 - {s_measured_angle[ANGLE_W-1], s_measured_angle};
        prev_in  = jvalid ? prev_error_reg[jidx] : '0;
        integ_in = jvalid ? integ_store_reg[jidx] : '0;
        diff_in  = {e_in[ERR_W-1], e_in} - {prev_in[ERR_W-1], prev_in};
    end

    // region decision and smoothing operands
    always_comb begin
        r_ext    = {{(MUL_XW-RES_W){r_reg[RES_W-1]}}, r_reg};
        off_ext  = MUL_XW'(off_reg);
        sa_w     = MUL_XW'(SMOOTH) - r_ext;
        sb_w     = r_ext + MUL_XW'(SMOOTH);
        fl_neg   = off_ext - r_ext;
        ex_pos   = off_ext + r_ext;
        neg_side = (r_reg <= -SMOOTH);
        pos_side = (r_reg >= SMOOTH);
    end

    // multiplier operands
    always_comb begin
        mul_ctl.load = in_fire || (state_reg == S_SPLIT && !neg_side && !pos_side);
        mul_ctl.step = (state_reg == S_MUL) || (state_reg == S_SQ);
        div_ctl.load = (state_reg == S_DLOAD);
        div_ctl.step = (state_reg == S_DIV);
        x2           = {{(MUL_XW-ERR_W){e_in[ERR_W-1]}}, e_in};
        if (state_reg == S_IDLE) begin
            x0  = {{(MUL_XW-ERR_W){e_in[ERR_W-1]}}, e_in};
            x1  = {{(MUL_XW-DIFF_W){diff_in[DIFF_W-1]}}, diff_in};
            mm0 = pg_reg;
            mm1 = dg_reg;
        end else begin
            x0  = MUL_XW'(sa_w[SQ_W-1:0]);
            x1  = MUL_XW'(sb_w[SQ_W-1:0]);
            mm0 = MUL_MW'(sa_w[SQ_W-1:0]);
            mm1 = MUL_MW'(sb_w[SQ_W-1:0]);
        end
    end

    apjd_smul u_mul0 (
        .aclk    (aclk),
        .ctl     (mul_ctl),
        .x       (x0),
        .m       (mm0),
        .prod_hi (hi0),
        .prod_lo (lo0)
    );

    apjd_smul u_mul1 (
        .aclk    (aclk),
        .ctl     (mul_ctl),
        .x       (x1),
        .m       (mm1),
        .prod_hi (hi1),
        .prod_lo (lo1)
    );

    apjd_smul u_mul2 (
        .aclk    (aclk),
        .ctl     (mul_ctl),
        .x       (x2),
        .m       (ig_reg),
        .prod_hi (hi2),
        .prod_lo (lo2)
    );

    assign sq0 = {hi0, lo0};
    assign sq1 = {hi1, lo1};

    apjd_sdiv u_div0 (
        .aclk     (aclk),
        .ctl      (div_ctl),
        .dividend (sq0[DIV_NW-1:0]),
        .quot     (q0)
    );

    apjd_sdiv u_div1 (
        .aclk     (aclk),
        .ctl      (div_ctl),
        .dividend (sq1[DIV_NW-1:0]),
        .quot     (q1)
    );

    // pid sums and clamps
    always_comb begin
        p_q   = {hi0, lo0[MUL_MW-1:8]};
        d_q   = {hi1, lo1[MUL_MW-1:8]};
        i_q   = {hi2, lo2[MUL_MW-1:8]};
        lim_s = 31'(lim_reg);
        isum  = {{(31-INTEG_W){integ_old_reg[INTEG_W-1]}}, integ_old_reg}
              + {{(31-PQ_W){i_q[PQ_W-1]}}, i_q};
        if (isum > lim_s) begin
            i_next = lim_s[INTEG_W-1:0];
        end else if (isum < -lim_s) begin
            i_next = INTEG_W'(-lim_s);
        end else begin
            i_next = isum[INTEG_W-1:0];
        end
        pd_next = {{(31-PQ_W){p_q[PQ_W-1]}}, p_q} + {{(31-PQ_W){d_q[PQ_W-1]}}, d_q};
        rsum    = {pd_reg[30], pd_reg} + {{(32-INTEG_W){i_reg[INTEG_W-1]}}, i_reg};
        if (rsum > RMAX_S) begin
            r_next = RMAX_S[RES_W-1:0];
        end else if (rsum < -RMAX_S) begin
            r_next = RES_W'(-RMAX_S);
        end else begin
            r_next = rsum[RES_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        fl_next      = fl_reg;
        ex_next      = ex_reg;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_MUL;
                    cnt_next   = '0;
                end
            end
            S_MUL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = S_INTEG;
                end
            end
            S_INTEG: state_next = S_RES;
            S_RES:   state_next = S_SPLIT;
            S_SPLIT: begin
                if (neg_side) begin
                    fl_next    = fl_neg[SETPT_W-1:0];
                    ex_next    = SETPT_W'(off_reg);
                    state_next = S_OUT;
                end else if (pos_side) begin
                    fl_next    = SETPT_W'(off_reg);
                    ex_next    = ex_pos[SETPT_W-1:0];
                    state_next = S_OUT;
                end else begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD: begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                fl_next    = SETPT_W'(off_reg) + SETPT_W'(q0);
                ex_next    = SETPT_W'(off_reg) + SETPT_W'(q1);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control, configuration and per-joint state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            pg_reg      <= PROP_GAIN_RST;
            ig_reg      <= INTEG_GAIN_RST;
            dg_reg      <= DERIV_GAIN_RST;
            lim_reg     <= INTEG_LIMIT_RST;
            off_reg     <= TONE_OFFSET_RST;
            for (int k = 0; k < JOINT_COUNT; k++) begin
                integ_store_reg[k] <= '0;
                prev_error_reg[k]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_PROP_GAIN:   pg_reg  <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:  ig_reg  <= cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:  dg_reg  <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_LIMIT: lim_reg <= cfg_data[LIMIT_W-1:0];
                    REG_TONE_OFFSET: off_reg <= cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_INTEG && jvalid_reg) begin
                integ_store_reg[JIDX_W'(sel_reg)] <= i_next;
                prev_error_reg[JIDX_W'(sel_reg)]  <= e_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sel_reg       <= s_joint_sel;
            jvalid_reg    <= jvalid;
            e_reg         <= e_in;
            integ_old_reg <= integ_in;
        end
        if (state_reg == S_INTEG) begin
            i_reg  <= i_next;
            pd_reg <= pd_next;
        end
        if (state_reg == S_RES) begin
            r_reg <= r_next;
        end
        fl_reg <= fl_next;
        ex_reg <= ex_next;
        if (out_load) begin
            out_sel_reg <= sel_reg;
            out_fl_reg  <= fl_reg;
            out_ex_reg  <= ex_reg;
        end
    end

    assign s_ready             = (state_reg == S_IDLE);
    assign cfg_ready           = 1'b1;
    assign m_valid             = m_valid_reg;
    assign m_joint_out         = out_sel_reg;
    assign m_flexor_setpoint   = out_fl_reg;
    assign m_extensor_setpoint = out_ex_reg;

endmodule

// ===== rtl/core/apjd_smul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle while step is set
// depends on apjd_pkg
module apjd_smul import apjd_pkg::*; (
    input  logic                     aclk,
    input  seq_ctl_t                 ctl,
    input  logic signed [MUL_XW-1:0] x,
    input  logic        [MUL_MW-1:0] m,
    output logic signed [MUL_XW:0]   prod_hi,
    output logic        [MUL_MW-1:0] prod_lo
);

    logic signed [MUL_XW:0]   acc_reg, acc_next;
    logic        [MUL_MW-1:0] lo_reg, lo_next;
    logic        [MUL_MW-1:0] m_reg, m_next;
    logic signed [MUL_XW-1:0] x_reg, x_next;
    logic signed [MUL_XW+1:0] sum;

    always_comb begin
        sum = {acc_reg[MUL_XW], acc_reg}
            + (m_reg[0] ? {{2{x_reg[MUL_XW-1]}}, x_reg} : '0);
        acc_next = acc_reg;
        lo_next  = lo_reg;
        m_next   = m_reg;
        x_next   = x_reg;
        if (ctl.load) begin
            acc_next = '0;
            lo_next  = '0;
            m_next   = m;
            x_next   = x;
        end else if (ctl.step) begin
            acc_next = sum[MUL_XW+1:1];
            lo_next  = {sum[0], lo_reg[MUL_MW-1:1]};
            m_next   = m_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
        m_reg   <= m_next;
        x_reg   <= x_next;
    end

    assign prod_hi = acc_reg;
    assign prod_lo = lo_reg;

endmodule

// ===== rtl/core/apjd_sdiv.sv =====
// bit-serial restoring divider by the smoothing constant, one quotient bit per cycle while step is set
// depends on apjd_pkg
module apjd_sdiv import apjd_pkg::*; (
    input  logic              aclk,
    input  seq_ctl_t          ctl,
    input  logic [DIV_NW-1:0] dividend,
    output logic [DIV_QW-1:0] quot
);

    localparam logic [DIV_RW:0] DEN = (DIV_RW + 1)'(SMOOTH_DIV);

    logic [DIV_RW-1:0] rem_reg, rem_next;
    logic [DIV_QW-1:0] sh_reg, sh_next;
    logic [DIV_QW-1:0] q_reg, q_next;
    logic [DIV_RW:0]   trial;
    logic [DIV_RW:0]   trial_sub;
    logic              ge;

    always_comb begin
        trial     = {rem_reg, sh_reg[DIV_QW-1]};
        trial_sub = trial - DEN;
        ge        = (trial >= DEN);
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        if (ctl.load) begin
            rem_next = dividend[DIV_NW-1:DIV_QW];
            sh_next  = dividend[DIV_QW-1:0];
            q_next   = '0;
        end else if (ctl.step) begin
            rem_next = ge ? trial_sub[DIV_RW-1:0] : trial[DIV_RW-1:0];
            sh_next  = sh_reg << 1;
            q_next   = {q_reg[DIV_QW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;

endmodule

// ===== sim/apjd_setpoint_checker.sv =====
// checker for the antagonistic pid joint drive: watches the sample, setpoint and
// register-write channels, predicts flexor/extensor setpoints per joint and compares them
// depends on apjd_pkg
module apjd_setpoint_checker import apjd_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [SEL_W-1:0]          s_joint_sel,
    input  logic signed [ANGLE_W-1:0] s_target_angle,
    input  logic signed [ANGLE_W-1:0] s_measured_angle,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [SEL_W-1:0]          m_joint_out,
    input  logic [SETPT_W-1:0]        m_flexor_setpoint,
    input  logic [SETPT_W-1:0]        m_extensor_setpoint,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output int                        setpoint_errors,
    output int                        setpoints_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SEL_W-1:0]   joint;
        logic [SETPT_W-1:0] flexor;
        logic [SETPT_W-1:0] extensor;
    } drive_result_t;

    longint prop_q, integ_q, deriv_q, limit_q, offset_q;
    longint integ_acc [JOINT_COUNT];
    longint last_err  [JOINT_COUNT];
    drive_result_t setpoint_queue [$];
    drive_result_t want, got;
    int errs;

    initial begin
        errs = 0;
    end

    function automatic longint clamp_sym(longint v, longint lim);
        if (v < -lim) begin
            return -lim;
        end
        if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    function automatic drive_result_t predict_setpoints(logic [SEL_W-1:0] sel,
                                                        logic signed [ANGLE_W-1:0] tgt,
                                                        logic signed [ANGLE_W-1:0] meas);
        longint err, prev, acc, p, d, i, r, a, b, flex, ext;
        bit known;
        drive_result_t res;
        known = (int'(sel) < JOINT_COUNT);
        err   = longint'(tgt) - longint'(meas);
        acc   = 0;
        prev  = 0;
        if (known) begin
            acc  = integ_acc[sel];
            prev = last_err[sel];
        end
        p = (prop_q * err) >>> 8;
        d = (deriv_q * (err - prev)) >>> 8;
        i = clamp_sym(acc + ((integ_q * err) >>> 8), limit_q);
        r = clamp_sym(p + d + i, RESULT_MAX);
        if (r <= -SMOOTH) begin
            flex = offset_q - r;
            ext  = offset_q;
        end else if (r < SMOOTH) begin
            a    = r - SMOOTH;
            b    = r + SMOOTH;
            flex = offset_q + (a * a) / SMOOTH_DIV;
            ext  = offset_q + (b * b) / SMOOTH_DIV;
        end else begin
            flex = offset_q;
            ext  = offset_q + r;
        end
        if (known) begin
            integ_acc[sel] = i;
            last_err[sel]  = err;
        end
        res.joint    = sel;
        res.flexor   = flex[SETPT_W-1:0];
        res.extensor = ext[SETPT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            prop_q   = PROP_GAIN_RST;
            integ_q  = INTEG_GAIN_RST;
            deriv_q  = DERIV_GAIN_RST;
            limit_q  = INTEG_LIMIT_RST;
            offset_q = TONE_OFFSET_RST;
            for (int k = 0; k < JOINT_COUNT; k++) begin
                integ_acc[k] = 0;
                last_err[k]  = 0;
            end
            setpoint_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PROP_GAIN:   prop_q   = cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:  integ_q  = cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:  deriv_q  = cfg_data[GAIN_W-1:0];
                    REG_INTEG_LIMIT: limit_q  = cfg_data[LIMIT_W-1:0];
                    REG_TONE_OFFSET: offset_q = cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.joint    = m_joint_out;
                got.flexor   = m_flexor_setpoint;
                got.extensor = m_extensor_setpoint;
                if (setpoint_queue.size() == 0) begin
                    errs++;
                    if (errs <= 10) begin
                        $display("%0t: setpoint with none pending: joint %0d flex %0d ext %0d",
                                 $realtime, got.joint, got.flexor, got.extensor);
                    end
                end else begin
                    want = setpoint_queue[0];
                    setpoint_queue.delete(0);
                    if (want.joint !== got.joint || want.flexor !== got.flexor ||
                        want.extensor !== got.extensor) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("%0t: mismatch joint %0d/%0d flex %0d/%0d ext %0d/%0d (exp/got)",
                                     $realtime, want.joint, got.joint, want.flexor, got.flexor,
                                     want.extensor, got.extensor);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                setpoint_queue = {setpoint_queue,
                                  predict_setpoints(s_joint_sel, s_target_angle,
                                                    s_measured_angle)};
            end
        end
        setpoint_errors <= errs;
        setpoints_due   <= setpoint_queue.size();
    end

endmodule

// ===== sim/tb_antagonistic_pid_joint_drive.sv =====
// testbench top for antagonistic_pid_joint_drive: clock, reset, joint samples,
// register writes and output back-pressure; checking is done in apjd_setpoint_checker
// depends on apjd_pkg, apjd_setpoint_checker and the block's rtl
module tb_antagonistic_pid_joint_drive import apjd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam int ROUNDS       = 8;
    localparam int ROUND_ITEMS  = 75;

    logic                      aclk                = 1'b0;
    logic                      aresetn             = 1'b0;
    logic                      s_valid             = 1'b0;
    logic                      s_ready;
    logic [SEL_W-1:0]          s_joint_sel         = '0;
    logic signed [ANGLE_W-1:0] s_target_angle      = '0;
    logic signed [ANGLE_W-1:0] s_measured_angle    = '0;
    logic                      m_valid;
    logic                      m_ready             = 1'b0;
    logic [SEL_W-1:0]          m_joint_out;
    logic [SETPT_W-1:0]        m_flexor_setpoint;
    logic [SETPT_W-1:0]        m_extensor_setpoint;
    logic                      cfg_valid           = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index           = '0;
    logic [CFG_DATA_W-1:0]     cfg_data            = '0;
    int                        setpoint_errors;
    int                        setpoints_due;
    bit                        calm                = 1'b0;

    antagonistic_pid_joint_drive i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_joint_sel         (s_joint_sel),
        .s_target_angle      (s_target_angle),
        .s_measured_angle    (s_measured_angle),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_joint_out         (m_joint_out),
        .m_flexor_setpoint   (m_flexor_setpoint),
        .m_extensor_setpoint (m_extensor_setpoint),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    apjd_setpoint_checker i_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_joint_sel         (s_joint_sel),
        .s_target_angle      (s_target_angle),
        .s_measured_angle    (s_measured_angle),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_joint_out         (m_joint_out),
        .m_flexor_setpoint   (m_flexor_setpoint),
        .m_extensor_setpoint (m_extensor_setpoint),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .setpoint_errors     (setpoint_errors),
        .setpoints_due       (setpoints_due)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAIL antagonistic_pid_joint_drive");
        $finish;
    end

    function automatic int draw_gap();
        int roll;
        if (calm) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic junk_bit();
        return ($urandom_range(0, 1) == 1) ? 1'b1 : 1'b0;
    endfunction

    // output back-pressure
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                stall = draw_gap();
            end else if (m_ready && $urandom_range(0, 15) == 0) begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [SEL_W-1:0] sel, input int tgt, input int meas);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_joint_sel      <= sel;
        s_target_angle   <= tgt[ANGLE_W-1:0];
        s_measured_angle <= meas[ANGLE_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // lowers valid once the last sample has been taken, then waits for all setpoints
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (setpoints_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [GAIN_W-1:0] pg, input logic [GAIN_W-1:0] ig,
                                  input logic [GAIN_W-1:0] dg, input logic [LIMIT_W-1:0] lim,
                                  input logic [OFFSET_W-1:0] off);
        write_reg(REG_PROP_GAIN,   {junk_bit(), pg});
        write_reg(REG_INTEG_GAIN,  {junk_bit(), ig});
        write_reg(REG_DERIV_GAIN,  {junk_bit(), dg});
        write_reg(REG_INTEG_LIMIT, lim);
        write_reg(REG_TONE_OFFSET, {junk_bit(), off});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(int cap);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return '0;
        end
        if (roll == 1) begin
            return '1;
        end
        if (roll == 2) begin
            return GAIN_W'($urandom);
        end
        return GAIN_W'($urandom_range(0, cap));
    endfunction

    task automatic randomize_settings();
        logic [LIMIT_W-1:0]  lim;
        logic [OFFSET_W-1:0] off;
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            lim = '0;
        end else if (roll == 1) begin
            lim = '1;
        end else if (roll == 2) begin
            lim = LIMIT_W'($urandom);
        end else begin
            lim = LIMIT_W'($urandom_range(0, 30000));
        end
        roll = $urandom_range(0, 5);
        if (roll == 0) begin
            off = '0;
        end else if (roll == 1) begin
            off = '1;
        end else begin
            off = OFFSET_W'($urandom);
        end
        apply_settings(pick_gain(1024), pick_gain(64), pick_gain(512), lim, off);
    endtask

    task automatic random_sample();
        logic [SEL_W-1:0] sel;
        int tgt, meas, kind;
        sel  = SEL_W'($urandom);
        kind = $urandom_range(0, 9);
        tgt  = $urandom;
        meas = $urandom;
        if (kind >= 3 && kind <= 8) begin
            tgt  = $urandom_range(0, 200000) - 100000;
            meas = tgt + $urandom_range(0, 4000) - 2000;
        end else if (kind == 9) begin
            meas = 0;
            case ($urandom_range(0, 5))
                0: tgt = -12800;
                1: tgt = -12799;
                2: tgt = 12799;
                3: tgt = 12800;
                4: tgt = 131071;
                default: tgt = -131072;
            endcase
        end
        send_sample(sel, tgt, meas);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: result equals error
        send_sample(0, 0, 0);
        send_sample(1, 131071, -131072);
        send_sample(2, -131072, 131071);
        send_sample(3, -12800, 0);
        send_sample(0, -12799, 0);
        send_sample(1, 12799, 0);
        send_sample(2, 12800, 0);
        send_sample(3, -131072, -131072);
        settle();

        // a write to an unmapped index, then every register at its maximum
        write_reg(REG_UNUSED, '1);
        apply_settings('1, '1, '1, '1, '1);
        send_sample(0, 131071, -131072);
        send_sample(0, -131072, 131071);
        send_sample(1, 1, 0);
        send_sample(1, 0, 1);
        send_sample(2, 131071, 131071);
        send_sample(3, -1, 0);
        settle();

        // integral wind-up, then a lowered clamp applied on the next update
        apply_settings('0, 16'd256, '0, '1, '0);
        send_sample(2, 60000, 0);
        send_sample(2, 60000, 0);
        settle();
        write_reg(REG_INTEG_LIMIT, 17'd1000);
        cfg_valid <= 1'b0;
        send_sample(3, 5, 0);
        send_sample(2, 0, 0);
        send_sample(2, -3000, 0);
        settle();

        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            calm = (rnd == 0);
            randomize_settings();
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                random_sample();
            end
            settle();
        end

        calm = 1'b0;
        repeat (60) @(posedge aclk);
        if (setpoint_errors == 0 && setpoints_due == 0) begin
            $display("PASS antagonistic_pid_joint_drive");
        end else begin
            $display("FAIL antagonistic_pid_joint_drive");
        end
        $finish;
    end

endmodule
